### src/int4_block_quantizer_packer_defines.svh
// Assertion macros shared by the int4 block quantiser RTL.
// Each macro expects clk_i and rst_ni to be visible in the using module.
`ifndef INT4_BLOCK_QUANTIZER_PACKER_DEFINES_SVH
`define INT4_BLOCK_QUANTIZER_PACKER_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define IQP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define IQP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/iqp_pkg.sv
// Shared types and constants of the int4 block quantiser and packer.
// Depends on nothing; iqp_front, iqp_back, the top level and the result checker import it.
package iqp_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ScaleW  = 21;
  localparam int unsigned FracBits = 12;
  localparam int unsigned UnitExp = FracBits + 8;
  localparam logic [ScaleW-1:0] ScaleUnit =
    (UnitExp >= ScaleW) ? {ScaleW{1'b1}} : ScaleW'(1 << UnitExp);
  // Ceiling of 2^27/7: exact floor division by seven for numerators below 2^24.
  localparam logic [24:0] Recip7 = 25'd19173962;

  typedef struct packed {
    logic              is_scale;
    logic [ScaleW-1:0] scale;
    logic [7:0]        packed_byte;
    logic              last;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCALE,
    BK_SCALE_OUT,
    BK_RD_LO,
    BK_RD_HI,
    BK_LOAD,
    BK_DIV,
    BK_EMIT
  } back_state_e;

  function automatic logic [SampleW-1:0] mag16(logic [SampleW-1:0] x);
    logic [SampleW:0] neg;
    neg = (SampleW+1)'(0) - {x[SampleW-1], x};
    return x[SampleW-1] ? neg[SampleW-1:0] : x;
  endfunction

endpackage

### src/iqp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module iqp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/iqp_fifo.sv
// Small register queue used for block jobs and for results.
// Depends on nothing.
module iqp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wp_q] <= data_i;
    end
  end

endmodule

### src/iqp_front.sv
// Front part: takes samples, writes them to the current store bank and tracks the peak.
// Depends on iqp_pkg; hands finished blocks to the back part as jobs.
module iqp_front #(
  parameter int unsigned BLOCK_MAX = 64,
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [iqp_pkg::SampleW-1:0] sample_i,
  input  logic                       last_i,
  output logic                       full_o,
  output logic                       we_o,
  output logic [AW:0]                waddr_o,
  output logic [iqp_pkg::SampleW-1:0] wdata_o,
  output logic                       job_push_o,
  output logic [CW+iqp_pkg::SampleW:0] job_o,
  input  logic                       job_done_i
);
  import iqp_pkg::*;

  logic [CW-1:0]      fill_q, fill_d, fill_inc;
  logic [SampleW-1:0] peak_q, peak_d, mag, peak_new;
  logic               bank_q, bank_d;
  logic [1:0]         busy_q, busy_d;
  logic               accept, close;

  assign full_o   = (busy_q == 2'd2);
  assign accept   = push_i && !full_o;
  assign mag      = mag16(sample_i);
  assign fill_inc = fill_q + CW'(1);
  assign peak_new = (mag > peak_q) ? mag : peak_q;
  assign close    = last_i || (fill_inc == CW'(BLOCK_MAX));

  assign we_o       = accept;
  assign waddr_o    = {bank_q, fill_q[AW-1:0]};
  assign wdata_o    = sample_i;
  assign job_push_o = accept && close;
  assign job_o      = {bank_q, fill_inc, peak_new};

  always_comb begin
    fill_d = fill_q;
    peak_d = peak_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (accept) begin
      if (close) begin
        fill_d = '0;
        peak_d = '0;
        bank_d = !bank_q;
      end else begin
        fill_d = fill_inc;
        peak_d = peak_new;
      end
    end
    if (job_push_o && !job_done_i) begin
      busy_d = busy_q + 2'd1;
    end else if (job_done_i && !job_push_o) begin
      busy_d = busy_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      peak_q <= '0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      fill_q <= fill_d;
      peak_q <= peak_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule

### src/iqp_back.sv
// Back part: turns one job into a scale result and packed code bytes.
// Depends on iqp_pkg and the assertion macros; reads the store and feeds the result queue.
`include "int4_block_quantizer_packer_defines.svh"

module iqp_back #(
  parameter int unsigned BLOCK_MAX = 64,
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_empty_i,
  input  logic [CW+iqp_pkg::SampleW:0] job_i,
  output logic                        job_pop_o,
  output logic                        rd_en_o,
  output logic [AW:0]                 rd_addr_o,
  input  logic [iqp_pkg::SampleW-1:0] rd_data_i,
  output logic                        res_push_o,
  output iqp_pkg::result_t            res_o,
  input  logic                        res_full_i,
  output logic                        done_o
);
  import iqp_pkg::*;

  back_state_e        state_q, state_d;
  logic               bank_q;
  logic [CW-1:0]      cnt_q, idx_q, idx1;
  logic [SampleW-1:0] peak_q, lo_raw_q, mag_lo, mag_hi;
  logic [48:0]        prod_q;
  logic [19:0]        rem_lo_q, rem_hi_q;
  logic [18:0]        dsh_q;
  logic [2:0]         q_lo_q, q_hi_q;
  logic               neg_lo_q, neg_hi_q;
  logic [1:0]         step_q;
  logic [CW:0]        idx_p1, idx_p2;
  logic               is_last, has_hi;
  logic [3:0]         code_lo, code_hi;

  assign idx1    = idx_q + CW'(1);
  assign idx_p1  = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_p2  = {1'b0, idx_q} + (CW+1)'(2);
  assign is_last = idx_p2 >= {1'b0, cnt_q};
  assign has_hi  = idx_p1 < {1'b0, cnt_q};
  assign mag_lo  = mag16(lo_raw_q);
  assign mag_hi  = mag16(rd_data_i);
  assign code_lo = neg_lo_q ? 4'(5'd0 - {2'b0, q_lo_q}) : {1'b0, q_lo_q};
  assign code_hi = neg_hi_q ? 4'(5'd0 - {2'b0, q_hi_q}) : {1'b0, q_hi_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) state_d = BK_SCALE;
      end
      BK_SCALE:     state_d = BK_SCALE_OUT;
      BK_SCALE_OUT: begin
        if (!res_full_i) state_d = BK_RD_LO;
      end
      BK_RD_LO:     state_d = BK_RD_HI;
      BK_RD_HI:     state_d = BK_LOAD;
      BK_LOAD:      state_d = BK_DIV;
      BK_DIV: begin
        if (step_q == 2'd2) state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (!res_full_i) state_d = is_last ? BK_IDLE : BK_RD_LO;
      end
      default:      state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o  = 1'b0;
    rd_en_o    = 1'b0;
    rd_addr_o  = {bank_q, idx_q[AW-1:0]};
    res_push_o = 1'b0;
    res_o      = '0;
    done_o     = 1'b0;
    unique case (state_q)
      BK_IDLE:  job_pop_o = !job_empty_i;
      BK_SCALE_OUT: begin
        res_push_o     = !res_full_i;
        res_o.is_scale = 1'b1;
        res_o.scale    = (peak_q == '0) ? ScaleUnit : prod_q[47:27];
      end
      BK_RD_LO: rd_en_o = 1'b1;
      BK_RD_HI: begin
        rd_en_o   = 1'b1;
        rd_addr_o = {bank_q, idx1[AW-1:0]};
      end
      BK_EMIT: begin
        res_push_o        = !res_full_i;
        res_o.packed_byte = {has_hi ? code_hi : 4'd0, code_lo};
        res_o.last        = is_last;
        done_o            = !res_full_i && is_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (job_pop_o) begin
        idx_q <= '0;
      end else if (state_q == BK_EMIT && !res_full_i) begin
        idx_q <= idx_q + CW'(2);
      end
      if (state_q == BK_LOAD) begin
        step_q <= '0;
      end else if (state_q == BK_DIV) begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      bank_q <= job_i[CW+SampleW];
      cnt_q  <= job_i[CW+SampleW-1 -: CW];
      peak_q <= job_i[SampleW-1:0];
    end
    if (state_q == BK_SCALE) begin
      prod_q <= 49'({peak_q, 8'd3}) * 49'(Recip7);
    end
    if (state_q == BK_RD_HI) begin
      lo_raw_q <= rd_data_i;
    end
    if (state_q == BK_LOAD) begin
      rem_lo_q <= 20'({4'b0, mag_lo} * 20'd14) + 20'(peak_q);
      rem_hi_q <= 20'({4'b0, mag_hi} * 20'd14) + 20'(peak_q);
      neg_lo_q <= lo_raw_q[SampleW-1];
      neg_hi_q <= rd_data_i[SampleW-1];
      dsh_q    <= {peak_q, 3'b0};
      q_lo_q   <= '0;
      q_hi_q   <= '0;
    end
    if (state_q == BK_DIV) begin
      if (dsh_q != '0 && rem_lo_q >= {1'b0, dsh_q}) begin
        rem_lo_q <= rem_lo_q - {1'b0, dsh_q};
        q_lo_q   <= {q_lo_q[1:0], 1'b1};
      end else begin
        q_lo_q   <= {q_lo_q[1:0], 1'b0};
      end
      if (dsh_q != '0 && rem_hi_q >= {1'b0, dsh_q}) begin
        rem_hi_q <= rem_hi_q - {1'b0, dsh_q};
        q_hi_q   <= {q_hi_q[1:0], 1'b1};
      end else begin
        q_hi_q   <= {q_hi_q[1:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  `IQP_ASSERT_NEVER(a_res_overflow, res_push_o && res_full_i, "Result pushed into a full queue.")
  `IQP_ASSERT_NEVER(a_job_underflow, job_pop_o && job_empty_i, "Job taken from an empty queue.")
  `IQP_ASSERT(a_zero_peak_code,
    (state_q == BK_EMIT && peak_q == '0) |-> (res_o.packed_byte == 8'd0),
    "Non-zero code for a zero peak.")
  `IQP_ASSERT(a_done_then_idle, done_o |=> (state_q == BK_IDLE),
    "Back part did not return to idle after a block.")

endmodule

### src/int4_block_quantizer_packer.sv
// Top level of the int4 block quantiser and packer.
// Depends on iqp_pkg, iqp_ram, iqp_fifo, iqp_front, iqp_back and the assertion macros.
//
// Input channel: a sample with last_of_block_i is transferred when push is high and full
// is low. Samples of a block are written to one bank of a two-bank store while the peak
// magnitude is tracked; a flagged sample, or the one that fills BLOCK_MAX entries, closes
// the block and queues it as a job.
// Result channel: while empty is low the oldest result is on the output ports, and it is
// transferred when pop is high. Each block gives one scale result, then one packed byte per
// pair of samples, the final byte marked with last_o.
// Timing: a sample is taken every cycle while a store bank is free. The back part computes
// the scale and outputs it, then forms each packed byte from two store reads, set-up, three
// restoring division steps and output.
// When the receiver stalls, results back up into the two-entry result queue, the back part
// waits, and once both banks hold unfinished blocks full goes high.
// Reset empties both queues, clears the fill count and peak and needs no clearing pass.
module int4_block_quantizer_packer #(
  parameter int unsigned BLOCK_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] sample_i,
  input  logic        last_of_block_i,
  output logic        empty,
  input  logic        pop,
  output logic        is_scale_o,
  output logic [20:0] scale_o,
  output logic [7:0]  packed_byte_o,
  output logic        last_o
);
  import iqp_pkg::*;

  localparam int unsigned AW = $clog2(BLOCK_MAX);
  localparam int unsigned CW = $clog2(BLOCK_MAX + 1);
  localparam int unsigned JW = CW + SampleW + 1;
  localparam int unsigned RW = $bits(result_t);

  logic               we, rd_en, job_push, job_full, job_pop, job_empty, done;
  logic [AW:0]        waddr, rd_addr;
  logic [SampleW-1:0] wdata, rd_data;
  logic [JW-1:0]      job_in, job_out;
  logic               res_push, res_full;
  result_t            res_in, res_out;
  logic [RW-1:0]      res_vec;

  iqp_front #(.BLOCK_MAX(BLOCK_MAX), .AW(AW), .CW(CW)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .sample_i, .last_i(last_of_block_i), .full_o(full),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .job_push_o(job_push), .job_o(job_in), .job_done_i(done)
  );

  iqp_ram #(.WIDTH(SampleW), .DEPTH(2 * (1 << AW))) u_store (
    .clk_i,
    .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(rd_data)
  );

  iqp_fifo #(.WIDTH(JW), .DEPTH(2)) u_job_q (
    .clk_i, .rst_ni,
    .push_i(job_push), .data_i(job_in), .full_o(job_full),
    .pop_i(job_pop), .data_o(job_out), .empty_o(job_empty)
  );

  iqp_back #(.BLOCK_MAX(BLOCK_MAX), .AW(AW), .CW(CW)) u_back (
    .clk_i, .rst_ni,
    .job_empty_i(job_empty), .job_i(job_out), .job_pop_o(job_pop),
    .rd_en_o(rd_en), .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .res_push_o(res_push), .res_o(res_in), .res_full_i(res_full),
    .done_o(done)
  );

  iqp_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
    .clk_i, .rst_ni,
    .push_i(res_push), .data_i(res_in), .full_o(res_full),
    .pop_i(pop), .data_o(res_vec), .empty_o(empty)
  );

  assign res_out       = result_t'(res_vec);
  assign is_scale_o    = res_out.is_scale;
  assign scale_o       = res_out.scale;
  assign packed_byte_o = res_out.packed_byte;
  assign last_o        = res_out.last;

  `IQP_ASSERT_NEVER(a_job_q_overflow, job_push && job_full, "Job queue overflow.")
  `IQP_ASSERT(a_full_after_two,
    (job_push && job_full == 1'b0 && job_empty == 1'b0 && !job_pop) |=> full,
    "Two waiting blocks did not stop input.")
  `IQP_ASSERT_NEVER(a_bank_clash, we && rd_en && waddr == rd_addr,
    "Store read and write at one entry.")

endmodule

### tb/iqp_result_checker.sv
// Result checker of the int4 block quantiser and packer testbench.
// Watches both channels, predicts the scale and packed bytes of each block and compares them.
// Depends on iqp_pkg for the result type and the unit scale.
`timescale 1ns / 100ps

module iqp_result_checker
  import iqp_pkg::*;
#(
  parameter int unsigned BLOCK_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [15:0] sample_i,
  input  logic        last_of_block_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        is_scale_o,
  input  logic [20:0] scale_o,
  input  logic [7:0]  packed_byte_o,
  input  logic        last_o,
  output int          fail_count_o,
  output int          pending_o
);

  logic [15:0] held_samples[BLOCK_MAX];
  int unsigned held_count;
  int unsigned peak_mag;
  result_t     expected_results[$];

  function automatic int unsigned sample_mag(logic [15:0] raw);
    return raw[15] ? 32'(17'h10000 - {1'b0, raw}) : 32'(raw);
  endfunction

  function automatic logic [3:0] sample_code(logic [15:0] raw, int unsigned peak);
    int unsigned q;
    q = 0;
    if (peak != 0) begin
      q = (14 * sample_mag(raw) + peak) / (2 * peak);
    end
    if (raw[15]) begin
      if (q > 8) q = 8;
      return 4'(16 - q);
    end
    if (q > 7) q = 7;
    return 4'(q);
  endfunction

  task automatic quantise_sample(logic [15:0] raw, logic close);
    result_t     res;
    int unsigned scale_val;
    logic [3:0]  hi_code;
    if (held_count < BLOCK_MAX) begin
      held_samples[held_count] = raw;
      held_count++;
    end
    if (sample_mag(raw) > peak_mag) peak_mag = sample_mag(raw);
    if (held_count >= BLOCK_MAX) close = 1'b1;
    if (close) begin
      if (peak_mag == 0) begin
        scale_val = 32'(ScaleUnit);
      end else begin
        scale_val = (peak_mag * 256 + 3) / 7;
        if (scale_val > 32'h1FFFFF) scale_val = 32'h1FFFFF;
      end
      res = '{is_scale: 1'b1, scale: 21'(scale_val), packed_byte: 8'h00, last: 1'b0};
      expected_results.push_back(res);
      for (int unsigned i = 0; i < held_count; i += 2) begin
        hi_code = 4'h0;
        if (i + 1 < held_count) hi_code = sample_code(held_samples[i+1], peak_mag);
        res = '{is_scale: 1'b0, scale: 21'h0,
                packed_byte: {hi_code, sample_code(held_samples[i], peak_mag)},
                last: (i + 2 >= held_count)};
        expected_results.push_back(res);
      end
      held_count = 0;
      peak_mag = 0;
    end
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic compare_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result transfer", packed_byte_o, 0);
      return;
    end
    want = expected_results.pop_front();
    if (is_scale_o !== want.is_scale) report_mismatch("is_scale", is_scale_o, want.is_scale);
    if (scale_o !== want.scale) report_mismatch("scale", scale_o, want.scale);
    if (packed_byte_o !== want.packed_byte) begin
      report_mismatch("packed_byte", packed_byte_o, want.packed_byte);
    end
    if (last_o !== want.last) report_mismatch("last", last_o, want.last);
  endtask

  initial begin
    fail_count_o = 0;
    held_count = 0;
    peak_mag = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) quantise_sample(sample_i, last_of_block_i);
      if (pop && !empty) compare_result();
    end
    pending_o <= expected_results.size();
  end

endmodule

### tb/int4_block_quantizer_packer_tb.sv
// Top of the int4 block quantiser and packer testbench: clock, reset, sample stimulus and verdict.
// Depends on iqp_pkg, the block int4_block_quantizer_packer and iqp_result_checker.
`timescale 1ns / 100ps

module int4_block_quantizer_packer_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned BLOCK_MAX_LEN = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] sample_i = '0;
  logic        last_of_block_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        is_scale_o;
  logic [20:0] scale_o;
  logic [7:0]  packed_byte_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;

  always #6 clk_i = ~clk_i;

  int4_block_quantizer_packer i_dut (
    .clk_i, .rst_ni, .push, .full, .sample_i, .last_of_block_i,
    .empty, .pop, .is_scale_o, .scale_o, .packed_byte_o, .last_o
  );

  iqp_result_checker i_checker (
    .clk_i, .rst_ni, .push, .full, .sample_i, .last_of_block_i,
    .empty, .pop, .is_scale_o, .scale_o, .packed_byte_o, .last_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= receiver_stall_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_sample(logic [15:0] value, logic close);
    logic taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    sample_i <= value;
    last_of_block_i <= close;
    do begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end while (!taken);
    sent_count++;
  endtask

  task automatic set_idling(int unsigned phase);
    case (phase % 4)
      0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      1: begin sender_idle_pct = 74; receiver_stall_pct = 0; end
      2: begin sender_idle_pct = 0; receiver_stall_pct = 74; end
      default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
    endcase
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(30)) - 15);
      2: return $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(3)) : 16'h8000;
      default: return 16'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  initial begin
    int unsigned block_len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h4000, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h000E, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0003, 1'b0);
    send_sample(16'hFFFD, 1'b0);
    send_sample(16'hFFF2, 1'b1);
    send_sample(16'h0000, 1'b1);
    push <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    while (sent_count < 300) begin
      set_idling(sent_count / 80);
      case ($urandom_range(9))
        0: block_len = BLOCK_MAX_LEN;
        1: block_len = $urandom_range(BLOCK_MAX_LEN - 1, 20);
        default: block_len = $urandom_range(12, 1);
      endcase
      for (int unsigned i = 0; i < block_len; i++) begin
        if (block_len == BLOCK_MAX_LEN) begin
          send_sample(random_sample(), 1'b0);
        end else begin
          send_sample(random_sample(), i == block_len - 1);
        end
      end
    end
    push <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/iqp_pkg.sv
src/iqp_ram.sv
src/iqp_fifo.sv
src/iqp_front.sv
src/iqp_back.sv
src/int4_block_quantizer_packer.sv
tb/iqp_result_checker.sv
tb/int4_block_quantizer_packer_tb.sv
